/* rtl/pcmcf_pkg.sv */
package pcmcf_pkg;

  localparam int CoordBits    = 20;
  localparam int CoefFracBits = 13;
  localparam int CoefW        = CoefFracBits + 1;
  localparam int BoxW         = 20;
  localparam int EnableBit    = 60;
  localparam int RegW         = 62;
  localparam int ProdW        = CoordBits + 2 + CoefW;
  localparam int AccW         = ProdW + 2;
  localparam int RowW         = AccW - CoefFracBits + 2;
  localparam int GapW         = 64;
  localparam int GapDiv       = 1000;
  localparam int NumRegs      = 8;
  localparam int CfgIdxW      = 3;
  localparam int QueueDepth   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegSensorX = 3'd0,
    RegSensorY = 3'd1,
    RegSensorZ = 3'd2,
    RegTargetX = 3'd3,
    RegTargetY = 3'd4,
    RegTargetZ = 3'd5,
    RegBoxLow  = 3'd6,
    RegBoxHigh = 3'd7
  } reg_idx_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    coord_t      z;
    logic [31:0] ofs;
    logic [7:0]  refl;
    logic [7:0]  tag;
    logic [7:0]  line;
  } point_t;

  // Classified item handed from front to back
  typedef struct packed {
    point_t      pt;
    logic        xform;
    logic        shift;
    logic [GapW-1:0] gap;
  } work_t;

  typedef logic signed [RowW-1:0] wide_t;

  function automatic logic signed [CoefW-1:0] coef(input logic [RegW-1:0] r, input int k);
    coef = r[k*CoefW +: CoefW];
  endfunction

  function automatic coord_t trans(input logic [RegW-1:0] r);
    logic [63:0] ext;
    ext = 64'(r);
    trans = ext[3*CoefW +: CoordBits];
  endfunction

  function automatic coord_t sat(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'((64'sd1 <<< (CoordBits-1)) - 1);
    lo = -hi - wide_t'(1);
    if (v > hi) sat = coord_t'(hi);
    else if (v < lo) sat = coord_t'(lo);
    else sat = coord_t'(v);
  endfunction

endpackage

/* rtl/pcmcf_row.sv */
// One transform row over two stages: products, then sum, round, shift and translation
module pcmcf_row (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pcmcf_pkg::RegW-1:0]  row_i,
  input  pcmcf_pkg::coord_t           x_i,
  input  pcmcf_pkg::coord_t           y_i,
  input  pcmcf_pkg::coord_t           z_i,
  input  logic                        en2_i,
  output pcmcf_pkg::wide_t            r_o
);
  import pcmcf_pkg::*;

  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;
  coord_t                  t_q;
  logic signed [AccW-1:0]  acc;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= ProdW'(coef(row_i, 0) * x_i);
      p1_q <= ProdW'(coef(row_i, 1) * y_i);
      p2_q <= ProdW'(coef(row_i, 2) * z_i);
      t_q  <= trans(row_i);
    end
  end

  // Sum, round half up, floor shift, add translation
  always_comb begin
    acc = AccW'(p0_q) + AccW'(p1_q) + AccW'(p2_q)
        + AccW'(64'sd1 <<< (CoefFracBits-1));
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) r_o <= RowW'(acc >>> CoefFracBits) + RowW'(t_q);
  end
endmodule

/* rtl/pcmcf_front.sv */
// Front: accept a point, classify it for the time shift, push to queue
module pcmcf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pcmcf_pkg::work_t      item_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output pcmcf_pkg::work_t      q_item_o
);
  import pcmcf_pkg::*;

  // Two-entry FIFO between front and back
  work_t                 mem_q [QueueDepth];
  logic                  wp_q, rp_q;
  logic [1:0]            cnt_q;
  logic                  push, pop;
  work_t                 w;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Time shift: gap/1000 == (gap>>3)/125, done in the back; here only classify
  always_comb begin
    w = item_i;
    w.shift = item_i.xform != item_i.shift;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/pcmcf_back.sv */
// Back: pipelined transforms, time shift, crop test, output register
module pcmcf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  pcmcf_pkg::work_t             q_item_i,
  input  logic [pcmcf_pkg::RegW-1:0]   regs_i [pcmcf_pkg::NumRegs],
  input  logic [60:0]                  box_lo_i,
  input  logic [59:0]                  box_hi_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pcmcf_pkg::point_t            out_o
);
  import pcmcf_pkg::*;

  localparam int NStg = 5;
  // ceil(2^68/125): ((gap>>3) * DivRecip) >> 68 equals gap/1000 for every 64-bit gap
  localparam logic [61:0] DivRecip = 62'h20C49BA5E353F7CF;

  // Pipeline advances as a whole when the output slot frees up
  logic            adv;
  logic [NStg-1:0] v_q;
  point_t          p_q [NStg];
  point_t          p2_d, p4_d;
  logic            xf_q [2];
  logic            sh_q [4];
  logic [GapW-1:0] g_q;
  logic [60:0]     gs;
  logic [63:0]     pll_q, plh_q, phl_q, phh_q, mid_q;
  logic [35:0]     hh_q;
  logic [67:0]     quo;
  logic [31:0]     q_q;
  wide_t           sx, sy, sz, tx, ty, tz;
  coord_t          nx, ny, nz;
  logic            in_box;
  point_t          oreg_q;
  logic            ov_q;

  assign adv = !ov_q || out_ready_i;
  assign q_ready_o = adv;

  pcmcf_row u_sx (.clk_i, .en_i(adv), .row_i(regs_i[RegSensorX]), .x_i(q_item_i.pt.x),
    .y_i(q_item_i.pt.y), .z_i(q_item_i.pt.z), .en2_i(adv), .r_o(sx));
  pcmcf_row u_sy (.clk_i, .en_i(adv), .row_i(regs_i[RegSensorY]), .x_i(q_item_i.pt.x),
    .y_i(q_item_i.pt.y), .z_i(q_item_i.pt.z), .en2_i(adv), .r_o(sy));
  pcmcf_row u_sz (.clk_i, .en_i(adv), .row_i(regs_i[RegSensorZ]), .x_i(q_item_i.pt.x),
    .y_i(q_item_i.pt.y), .z_i(q_item_i.pt.z), .en2_i(adv), .r_o(sz));

  // First-frame coordinates after saturation (valid at stage 2)
  always_comb begin
    nx = xf_q[1] ? sat(sx) : p_q[1].x;
    ny = xf_q[1] ? sat(sy) : p_q[1].y;
    nz = xf_q[1] ? sat(sz) : p_q[1].z;
  end

  pcmcf_row u_tx (.clk_i, .en_i(adv), .row_i(regs_i[RegTargetX]), .x_i(p_q[2].x),
    .y_i(p_q[2].y), .z_i(p_q[2].z), .en2_i(adv), .r_o(tx));
  pcmcf_row u_ty (.clk_i, .en_i(adv), .row_i(regs_i[RegTargetY]), .x_i(p_q[2].x),
    .y_i(p_q[2].y), .z_i(p_q[2].z), .en2_i(adv), .r_o(ty));
  pcmcf_row u_tz (.clk_i, .en_i(adv), .row_i(regs_i[RegTargetZ]), .x_i(p_q[2].x),
    .y_i(p_q[2].y), .z_i(p_q[2].z), .en2_i(adv), .r_o(tz));

  // Inclusive box test in the crop frame
  always_comb begin
    in_box = box_lo_i[EnableBit]
      && tx >= wide_t'(coord_t'(box_lo_i[0 +: BoxW]))
      && tx <= wide_t'(coord_t'(box_hi_i[0 +: BoxW]))
      && ty >= wide_t'(coord_t'(box_lo_i[20 +: BoxW]))
      && ty <= wide_t'(coord_t'(box_hi_i[20 +: BoxW]))
      && tz >= wide_t'(coord_t'(box_lo_i[40 +: BoxW]))
      && tz <= wide_t'(coord_t'(box_hi_i[40 +: BoxW]));
  end

  // gap/1000: four 32x32 partial products, then two summing stages;
  // only bits 68..99 of the full product are kept
  assign gs  = g_q[GapW-1:3];
  assign quo = 68'(mid_q) + {hh_q, 32'd0};

  // Stage payloads with the updated fields merged in
  always_comb begin
    p2_d = p_q[1];
    p2_d.x = nx;
    p2_d.y = ny;
    p2_d.z = nz;
    p4_d = p_q[3];
    p4_d.ofs = p_q[3].ofs + (sh_q[3] ? q_q : 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0]  <= q_item_i.pt;
      xf_q[0] <= q_item_i.xform;
      sh_q[0] <= q_item_i.shift;
      g_q     <= q_item_i.gap;
      p_q[1]  <= p_q[0];
      xf_q[1] <= xf_q[0];
      sh_q[1] <= sh_q[0];
      pll_q <= 64'(gs[31:0]) * 64'(DivRecip[31:0]);
      plh_q <= 64'(gs[31:0]) * 64'(DivRecip[61:32]);
      phl_q <= 64'(gs[60:32]) * 64'(DivRecip[31:0]);
      phh_q <= 64'(gs[60:32]) * 64'(DivRecip[61:32]);
      p_q[2]  <= p2_d;
      sh_q[2] <= sh_q[1];
      mid_q <= 64'(pll_q[63:32]) + plh_q + phl_q;
      hh_q  <= phh_q[35:0];
      p_q[3]  <= p_q[2];
      sh_q[3] <= sh_q[2];
      q_q   <= quo[67:36];
      p_q[4] <= p4_d;
    end
  end

  assign out_o = oreg_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i) begin
    if (adv) oreg_q <= p_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q  <= {v_q[NStg-2:0], q_valid_i};
      ov_q <= v_q[4] && !in_box;
    end
  end
endmodule

/* rtl/point_cloud_merge_crop_filter.sv */
// Data path: an accepted point passes the front queue, then the back pipeline stages
// p_q[0] to p_q[4] and the output register before its result is valid.
// Throughput: one point per cycle; the back pipeline stalls only on output backpressure.
// The gap/1000 term uses four 32x32 reciprocal partial products and two sum stages.
// Reset: rst_ni asynchronous active low clears queue and valid flags and loads
// identity transforms and the default enabled crop box.
module point_cloud_merge_crop_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               source_i,
  input  logic                               earlier_source_i,
  input  logic [63:0]                        timebase_gap_ns_i,
  input  logic signed [pcmcf_pkg::CoordBits-1:0] x_mm_i,
  input  logic signed [pcmcf_pkg::CoordBits-1:0] y_mm_i,
  input  logic signed [pcmcf_pkg::CoordBits-1:0] z_mm_i,
  input  logic [31:0]                        offset_time_i,
  input  logic [7:0]                         reflectivity_i,
  input  logic [7:0]                         point_tag_i,
  input  logic [7:0]                         line_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pcmcf_pkg::CoordBits-1:0] out_x_mm_o,
  output logic signed [pcmcf_pkg::CoordBits-1:0] out_y_mm_o,
  output logic signed [pcmcf_pkg::CoordBits-1:0] out_z_mm_o,
  output logic [31:0]                        out_offset_time_o,
  output logic [7:0]                         out_reflectivity_o,
  output logic [7:0]                         out_tag_o,
  output logic [7:0]                         out_line_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pcmcf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [63:0]                        cfg_data_i
);
  import pcmcf_pkg::*;

  logic [RegW-1:0] regs_q [NumRegs];
  work_t  item, q_item;
  logic   q_valid, q_ready;
  point_t opt;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegSensorX] <= RegW'(64'd8192);
      regs_q[RegSensorY] <= RegW'(64'd134217728);
      regs_q[RegSensorZ] <= RegW'(64'd2199023255552);
      regs_q[RegTargetX] <= RegW'(64'd8192);
      regs_q[RegTargetY] <= RegW'(64'd134217728);
      regs_q[RegTargetZ] <= RegW'(64'd2199023255552);
      regs_q[RegBoxLow]  <= RegW'(64'd2305294351863905304);
      regs_q[RegBoxHigh] <= RegW'(64'd1649268490242000);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegBoxLow:  regs_q[RegBoxLow]  <= RegW'(cfg_data_i[60:0]);
        RegBoxHigh: regs_q[RegBoxHigh] <= RegW'(cfg_data_i[59:0]);
        default:    regs_q[cfg_index_i] <= cfg_data_i[RegW-1:0];
      endcase
    end
  end

  // Pack the input transaction; shift flag carries earlier_source until classified
  always_comb begin
    item.pt.x    = x_mm_i;
    item.pt.y    = y_mm_i;
    item.pt.z    = z_mm_i;
    item.pt.ofs  = offset_time_i;
    item.pt.refl = reflectivity_i;
    item.pt.tag  = point_tag_i;
    item.pt.line = line_number_i;
    item.xform   = source_i;
    item.shift   = earlier_source_i;
    item.gap     = timebase_gap_ns_i;
  end

  pcmcf_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .item_i(item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item));

  pcmcf_back u_back (.clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_item_i(q_item), .regs_i(regs_q), .box_lo_i(regs_q[RegBoxLow][60:0]),
    .box_hi_i(regs_q[RegBoxHigh][59:0]), .out_valid_o, .out_ready_i, .out_o(opt));

  assign out_x_mm_o         = opt.x;
  assign out_y_mm_o         = opt.y;
  assign out_z_mm_o         = opt.z;
  assign out_offset_time_o  = opt.ofs;
  assign out_reflectivity_o = opt.refl;
  assign out_tag_o          = opt.tag;
  assign out_line_o         = opt.line;

  // A stalled result stays valid and holds its offset time
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_offset_time_o))
    else $error("result changed under stall");

  // The front refuses input only while the queue holds items
  a_in_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("front stalled with empty queue");

  // Back takes from the queue whenever the output slot is free
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> q_ready)
    else $error("back stalled with free output");
endmodule
